/* sv/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared sizes, request and response beats, and codes for the bounded
// double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

	// queue sizing
	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int SUM_W      = $clog2(2 * CAPACITY);

	// fixed field widths of the beats
	localparam int MODE_W = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 9;

	// request modes
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_POS   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd5;
	localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

	// response status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  data_out;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

endpackage

/* sv/bdeq_ram.sv */
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module bdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of data words held in a ring RAM, addressed by a front
// pointer and an entry count.
// ----------------------------------------------------------------------------
// Each request beat is decoded in the cycle it is accepted: pointer and count
// update at once, and the request makes at most one RAM access, a write for a
// push or a read for a pop, peek or position read. Read data is registered
// in the RAM beside stage 1 and then moves into the response register, and a
// new request can be taken every cycle while stage 1 is empty or the response
// register is free or being drained. A push into a full queue answers with
// the full status; pop, peek or read on an empty queue answers empty; a read
// position at or beyond the count answers out of range. Data is zero on every
// response that returns no word. Clear only resets the count.
module bounded_double_ended_queue
	import bdeq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// queue state
	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	// request decode results
	logic             accept;
	logic             full;
	logic             empty;
	logic [PTR_W-1:0] offset;
	logic [SUM_W-1:0] slot_sum;
	logic [PTR_W-1:0] slot;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] front_inc;
	logic [PTR_W-1:0] front_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic [STAT_W-1:0] status_nxt;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic             ram_re;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// stage 1: request in flight while RAM read completes
	logic              valid_s1;
	logic              rd_s1;
	logic [STAT_W-1:0] status_s1;
	logic [OCC_W-1:0]  occ_s1;

	// response register
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || rsp_free;
	assign accept    = req_valid && req_ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// neighbor pointers around the front
	assign front_dec = (front_q == '0) ? PTR_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	// ring slot at an offset from the front
	always_comb begin
		unique case (req.mode) inside
			MODE_READ_POS:                offset = PTR_W'(req.position);
			MODE_POP_BACK, MODE_PEEK_BACK: offset = PTR_W'(count_q - 1'b1);
			MODE_PUSH_BACK:               offset = PTR_W'(count_q);
			default:                      offset = '0;
		endcase
	end

	assign slot_sum = SUM_W'(front_q) + SUM_W'(offset);
	assign slot     = (slot_sum >= SUM_W'(CAPACITY))
		? PTR_W'(slot_sum - SUM_W'(CAPACITY)) : PTR_W'(slot_sum);

	// request decode
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		ram_we     = 1'b0;
		ram_waddr  = slot;
		ram_re     = 1'b0;
		unique case (req.mode) inside
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ram_we    = 1'b1;
					count_nxt = count_q + 1'b1;
					if (req.mode == MODE_PUSH_FRONT) begin
						front_nxt = front_dec;
						ram_waddr = front_dec;
					end
				end
			end
			MODE_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (req.mode == MODE_READ_POS
						&& (POS_W + CNT_W)'(req.position)
						>= (POS_W + CNT_W)'(count_q)) begin
					status_nxt = ST_RANGE;
				end else begin
					ram_re = 1'b1;
					if (req.mode == MODE_POP_FRONT) begin
						front_nxt = front_inc;
						count_nxt = count_q - 1'b1;
					end else if (req.mode == MODE_POP_BACK) begin
						count_nxt = count_q - 1'b1;
					end
				end
			end
		endcase
	end

	// ring store
	bdeq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we && accept),
		.waddr(ram_waddr),
		.wdata(req.value[DATA_WIDTH-1:0]),
		.re   (ram_re && accept),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= ram_re;
			status_s1 <= status_nxt;
			occ_s1    <= OCC_W'(count_nxt);
		end
	end

	// response register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// response register payload
	always_ff @(posedge clk) begin
		if (rsp_free && valid_s1) begin
			rsp_q.data_out  <= rd_s1 ? VAL_W'(ram_rdata) : '0;
			rsp_q.status    <= status_s1;
			rsp_q.occupancy <= occ_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* dv/bdeq_checker.sv */
// ----------------------------------------------------------------------------
// bdeq_checker
// Watches both channels of the bounded double-ended queue, predicts every
// response from its own copy of the ring, pointer and count, and compares
// each accepted response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bdeq_checker
	import bdeq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   pending,
	output int   fail_count
);

	// shadow of the queue contents
	logic [DATA_WIDTH-1:0] ring [CAPACITY];
	int front_ptr;
	int entry_cnt;

	// responses predicted but not yet seen, oldest first
	rsp_t answers_due [$];
	int mismatches;

	// ring index of the entry at a given distance from the front
	function automatic int slot_of(input int offset);
		return (front_ptr + offset) % CAPACITY;
	endfunction

	// apply one request to the shadow queue and return its response
	function automatic rsp_t apply_request(input req_t r);
		rsp_t ans;
		int offset;
		ans = '0;
		ans.status = ST_OK;
		case (r.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (entry_cnt >= CAPACITY) begin
					ans.status = ST_FULL;
				end else if (r.mode == MODE_PUSH_FRONT) begin
					front_ptr = (front_ptr == 0) ? CAPACITY - 1 : front_ptr - 1;
					ring[front_ptr] = DATA_WIDTH'(r.value);
					entry_cnt++;
				end else begin
					ring[slot_of(entry_cnt)] = DATA_WIDTH'(r.value);
					entry_cnt++;
				end
			end
			// clear drops the count only, words stay in the ring
			MODE_CLEAR: entry_cnt = 0;
			default: begin
				if (entry_cnt == 0) begin
					ans.status = ST_EMPTY;
				end else if (r.mode == MODE_READ_POS && int'(r.position) >= entry_cnt) begin
					ans.status = ST_RANGE;
				end else begin
					if (r.mode == MODE_READ_POS)
						offset = int'(r.position);
					else if (r.mode == MODE_POP_FRONT || r.mode == MODE_PEEK_FRONT)
						offset = 0;
					else
						offset = entry_cnt - 1;
					ans.data_out = VAL_W'(ring[slot_of(offset)]);
					if (r.mode == MODE_POP_FRONT) begin
						front_ptr = slot_of(1);
						entry_cnt--;
					end else if (r.mode == MODE_POP_BACK) begin
						entry_cnt--;
					end
				end
			end
		endcase
		ans.occupancy = OCC_W'(entry_cnt);
		return ans;
	endfunction

	// one line per mismatch, printing capped so a broken run stays short
	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch on %s at %0t: got 0x%0h, want 0x%0h", field, $time, got, want);
	endtask

	// predict on request beats, compare on response beats
	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			front_ptr = 0;
			entry_cnt = 0;
			answers_due.delete();
		end else begin
			if (req_valid && req_ready)
				answers_due.push_back(apply_request(req));
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch("response beat with nothing due", rsp, '0);
				end else begin
					want = answers_due.pop_front();
					if (rsp.data_out !== want.data_out)
						report_mismatch("data_out", rsp.data_out, want.data_out);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.occupancy !== want.occupancy)
						report_mismatch("occupancy", rsp.occupancy, want.occupancy);
				end
			end
		end
		pending <= answers_due.size();
		fail_count <= mismatches;
	end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives request beats into the bounded double-ended queue: a directed run
// over empty, range and clear cases, then random phases that fill the queue
// past full, churn it and drain it, with random idling on both channels and
// long response hold-offs. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top
	import bdeq_pkg::*;
;

	localparam int RANDOM_BEATS    = 1850;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 10;

	typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN, PH_CHURN} phase_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int pending;
	int fail_count;
	int idle_cycles = 0;
	int last_occ = 0;
	int send_calm = 0;
	int recv_calm = 0;

	bounded_double_ended_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	bdeq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #5 clk = ~clk;

	// idle cycles before a beat, with occasional stretches of back-to-back beats
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// mode mix depends on whether the phase grows, churns or shrinks the queue
	function automatic logic [MODE_W-1:0] pick_mode(input phase_t kind);
		int push_w;
		int pop_w;
		int clear_w;
		int roll;
		case (kind)
			PH_FILL: begin
				push_w = 88; pop_w = 4; clear_w = 0;
			end
			PH_DRAIN: begin
				push_w = 10; pop_w = 60; clear_w = 0;
			end
			PH_CHURN: begin
				push_w = 40; pop_w = 30; clear_w = 4;
			end
			default: begin
				push_w = 45; pop_w = 30; clear_w = 1;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < push_w)
			return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		if (roll < push_w + pop_w)
			return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
		if (roll < push_w + pop_w + clear_w)
			return MODE_CLEAR;
		case ($urandom_range(0, 3))
			0, 1: return MODE_READ_POS;
			2: return MODE_PEEK_FRONT;
			default: return MODE_PEEK_BACK;
		endcase
	endfunction

	// data words with some weight on the extremes
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(VAL_W-1){1'b0}}};
			3: return VAL_W'(1);
			default: return $urandom;
		endcase
	endfunction

	// positions mostly inside the count, some at the boundary, some anywhere
	function automatic logic [POS_W-1:0] pick_position(input int occ);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5 && occ > 0)
			return POS_W'($urandom_range(0, occ - 1));
		if (roll < 7)
			return POS_W'(occ + int'($urandom_range(0, 2)) - 1);
		return POS_W'($urandom);
	endfunction

	// present one request beat and hold it until accepted
	task automatic offer(input logic [MODE_W-1:0] op, input logic [VAL_W-1:0] word,
			input logic [POS_W-1:0] pos);
		req_t beat;
		int gap;
		beat.mode = op;
		beat.value = word;
		beat.position = pos;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// response side: random stalls plus two long hold-offs that back up the block
	initial begin : drain_side
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 400 || taken == 1300)
				gap = HOLD_OFF_CYCLES;
			else
				gap = draw_gap(recv_calm);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			last_occ <= int'(rsp.occupancy);
			taken++;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("** bounded_double_ended_queue: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus and verdict
	initial begin : feed_side
		phase_t kind;
		int phase_len;
		int sent;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: every read-type request and a clear
		offer(MODE_POP_FRONT, '1, pick_position(0));
		offer(MODE_POP_BACK, '0, pick_position(0));
		offer(MODE_READ_POS, pick_value(), '0);
		offer(MODE_PEEK_FRONT, pick_value(), '1);
		offer(MODE_PEEK_BACK, pick_value(), pick_position(0));
		offer(MODE_CLEAR, '1, '1);
		// four words at both ends, then look at them
		offer(MODE_PUSH_BACK, '1, '0);
		offer(MODE_PUSH_FRONT, '0, '1);
		offer(MODE_PUSH_BACK, 32'hA5A5_A5A5, 8'h55);
		offer(MODE_PUSH_FRONT, 32'h5A5A_5A5A, 8'hAA);
		offer(MODE_PEEK_FRONT, '0, '0);
		offer(MODE_PEEK_BACK, '0, '0);
		offer(MODE_READ_POS, '1, 8'd0);
		offer(MODE_READ_POS, '0, 8'd3);
		// positions at and beyond the count
		offer(MODE_READ_POS, '0, 8'd4);
		offer(MODE_READ_POS, '0, '1);
		offer(MODE_POP_FRONT, '0, '0);
		offer(MODE_POP_BACK, '0, '0);
		// clear keeps the words but empties the queue
		offer(MODE_CLEAR, '0, '0);
		offer(MODE_READ_POS, '0, 8'd0);
		offer(MODE_PUSH_FRONT, {1'b1, {(VAL_W-1){1'b0}}}, '1);
		offer(MODE_POP_BACK, '1, '1);
		offer(MODE_PUSH_BACK, {1'b0, {(VAL_W-1){1'b1}}}, '1);
		offer(MODE_PEEK_FRONT, '1, '0);

		// random phases: fill past full, mix, drain to empty, churn with clears
		sent = 0;
		n = 0;
		while (sent < RANDOM_BEATS) begin
			kind = phase_t'(n % 4);
			if (kind == PH_FILL || kind == PH_DRAIN)
				phase_len = 330;
			else
				phase_len = $urandom_range(150, 250);
			for (int i = 0; i < phase_len && sent < RANDOM_BEATS; i++) begin
				offer(pick_mode(kind), pick_value(), pick_position(last_occ));
				sent++;
			end
			n++;
		end
		req_valid <= 1'b0;

		// wait out every outstanding response, then a short quiet tail
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** bounded_double_ended_queue: PASSED **");
		else
			$display("** bounded_double_ended_queue: FAILED **");
		$finish;
	end

endmodule
